@@ rtl/brr_pkg.sv @@
// Shared types, constants and helpers for the BRR ADPCM sample decoder.
// Depends on nothing; the RTL files refer to it by scoped names, the verification files import it.
`default_nettype none

package brr_pkg;

    // Voice and block geometry
    localparam int VOICES            = 8;
    localparam int VOICE_W           = 3;
    localparam int VIDX_W            = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int NIBBLES_PER_BLOCK = 16;
    localparam int CNT_W             = $clog2(NIBBLES_PER_BLOCK + 1);

    // Datapath widths
    localparam int BYTE_W    = 8;
    localparam int NIB_W     = 4;
    localparam int SHIFT_W   = 4;
    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 8;
    localparam int FRAC_BITS = 6;
    localparam int PROD_W    = SAMPLE_W + COEF_W;
    // scaled nibble (19 bits) plus two terms of up to 18 bits
    localparam int ACC_W     = 21;

    localparam int SAMPLE_MAX = 32767;
    localparam int SAMPLE_MIN = -32768;

    // Header byte layout
    localparam int HDR_SHIFT_LSB = 4;
    localparam int HDR_FILT_LSB  = 2;
    localparam int HDR_LOOP_BIT  = 1;
    localparam int HDR_END_BIT   = 0;

    // Configuration register map
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_F1_NEWER = 3'd0,
        CFG_F2_NEWER = 3'd1,
        CFG_F2_OLDER = 3'd2,
        CFG_F3_NEWER = 3'd3,
        CFG_F3_OLDER = 3'd4
    } cfg_reg_t;

    localparam logic signed [COEF_W-1:0] COEF_F1_NEWER_RST = 8'sd60;
    localparam logic signed [COEF_W-1:0] COEF_F2_NEWER_RST = 8'sd115;
    localparam logic signed [COEF_W-1:0] COEF_F2_OLDER_RST = -8'sd52;
    localparam logic signed [COEF_W-1:0] COEF_F3_NEWER_RST = 8'sd98;
    localparam logic signed [COEF_W-1:0] COEF_F3_OLDER_RST = -8'sd55;

    // Filter selection codes
    typedef enum logic [1:0] {
        FILT_NONE  = 2'd0,
        FILT_ONE   = 2'd1,
        FILT_TWO   = 2'd2,
        FILT_THREE = 2'd3
    } filt_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_NEWER = 2'd1,
        ST_OLDER = 2'd2,
        ST_EMIT  = 2'd3
    } seq_state_t;

    // Control of the shared multiply-accumulate unit
    typedef struct packed {
        logic en;
        logic first;
    } pred_ctl_t;

    // Clamp the accumulator to a signed 16-bit sample
    function automatic logic signed [SAMPLE_W-1:0] sat_sample(
        input logic signed [ACC_W-1:0] x
    );
        logic signed [SAMPLE_W-1:0] res;
        if (x > ACC_W'(SAMPLE_MAX))
            res = SAMPLE_W'(SAMPLE_MAX);
        else if (x < ACC_W'(SAMPLE_MIN))
            res = SAMPLE_W'(SAMPLE_MIN);
        else
            res = SAMPLE_W'(x);
        return res;
    endfunction

endpackage

`default_nettype wire

@@ rtl/brr_pred_unit.sv @@
// Shared multiply-accumulate unit: one weighted history term per cycle while ctl.en
// is high, floored by the 6-bit fraction, added to the scaled nibble. Uses brr_pkg.
`default_nettype none

module brr_pred_unit (
    input  wire logic                                  clk,
    input  wire brr_pkg::pred_ctl_t                    ctl,
    input  wire logic signed [brr_pkg::SAMPLE_W-1:0]   operand,
    input  wire logic signed [brr_pkg::COEF_W-1:0]     weight,
    input  wire logic signed [brr_pkg::ACC_W-1:0]      base,
    output logic signed [brr_pkg::ACC_W-1:0]           acc
);

    logic signed [brr_pkg::PROD_W-1:0] product;
    logic signed [brr_pkg::ACC_W-1:0]  term;
    logic signed [brr_pkg::ACC_W-1:0]  acc_reg;
    logic signed [brr_pkg::ACC_W-1:0]  acc_next;

    // Weight the history sample and drop the fraction (floor)
    assign product = operand * weight;
    assign term    = brr_pkg::ACC_W'(product >>> brr_pkg::FRAC_BITS);

    // Start from the scaled nibble on the first term, else accumulate
    assign acc_next = (ctl.first ? base : acc_reg) + term;

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

@@ rtl/brr_adpcm_sample_decoder_top.sv @@
// Top level of the multi-channel BRR ADPCM sample decoder: sequencer,
// per-voice history, coefficient registers and output register.
// Depends on brr_pkg and brr_pred_unit.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------------
//  in      | request   | in_valid / in_stall   | voice, data_byte, restart
//  out     | result    | out_valid / out_stall | sample, out_voice, block_end,
//          |           |                       | loop_back, stop_play, last
//  cfg     | write     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A header request is loaded in the idle state. A data request steps each nibble,
// upper first (only that one when the block ends on it), through newer, older and
// load steps: each passes the one multiplier twice, then saturates. in_stall is high from
// the cycle after a data request until its last sample is loaded. A stalled output
// holds its sample; the sequencer waits in its load step until the register frees.
// Reset is asynchronous, active low, leaves every voice expecting a header; cfg_ready is always high.
`default_nettype none

module brr_adpcm_sample_decoder_top (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,

    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic [brr_pkg::VOICE_W-1:0]           voice,
    input  wire logic [brr_pkg::BYTE_W-1:0]            data_byte,
    input  wire logic                                  restart,

    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic signed [brr_pkg::SAMPLE_W-1:0]        sample,
    output logic [brr_pkg::VOICE_W-1:0]                out_voice,
    output logic                                       block_end,
    output logic                                       loop_back,
    output logic                                       stop_play,
    output logic                                       last,

    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [brr_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [brr_pkg::COEF_W-1:0]            cfg_data
);

    // Coefficient registers
    logic signed [brr_pkg::COEF_W-1:0] f1_newer_reg;
    logic signed [brr_pkg::COEF_W-1:0] f2_newer_reg;
    logic signed [brr_pkg::COEF_W-1:0] f2_older_reg;
    logic signed [brr_pkg::COEF_W-1:0] f3_newer_reg;
    logic signed [brr_pkg::COEF_W-1:0] f3_older_reg;

    // Per-voice state
    logic signed [brr_pkg::SAMPLE_W-1:0] prev_newer_reg [brr_pkg::VOICES];
    logic signed [brr_pkg::SAMPLE_W-1:0] prev_older_reg [brr_pkg::VOICES];
    logic [brr_pkg::BYTE_W-1:0]          header_reg     [brr_pkg::VOICES];
    logic [brr_pkg::CNT_W-1:0]           count_reg      [brr_pkg::VOICES];
    logic                                await_reg      [brr_pkg::VOICES];

    // Request under work
    brr_pkg::seq_state_t          state_reg;
    brr_pkg::seq_state_t          state_next;
    logic [brr_pkg::VOICE_W-1:0]  voice_reg;
    logic [brr_pkg::BYTE_W-1:0]   byte_reg;
    logic                         nib_sel_reg;

    // Output register
    logic                                 out_valid_reg;
    logic signed [brr_pkg::SAMPLE_W-1:0]  sample_reg;
    logic [brr_pkg::VOICE_W-1:0]          out_voice_reg;
    logic                                 block_end_reg;
    logic                                 loop_back_reg;
    logic                                 stop_play_reg;
    logic                                 last_reg;

    logic                                 in_accept;
    logic                                 voice_ok;
    logic [brr_pkg::VIDX_W-1:0]           vidx_in;
    logic [brr_pkg::VIDX_W-1:0]           vidx;
    logic                                 take_header;
    logic                                 start_data;
    logic                                 out_free;
    logic                                 emit_fire;

    logic [brr_pkg::BYTE_W-1:0]           hdr;
    brr_pkg::filt_t                       filt;
    logic [brr_pkg::SHIFT_W-1:0]          shift;
    logic signed [brr_pkg::COEF_W-1:0]    w_newer;
    logic signed [brr_pkg::COEF_W-1:0]    w_older;
    logic [brr_pkg::NIB_W-1:0]            nibble;
    logic signed [brr_pkg::ACC_W-1:0]     nib_ext;
    logic signed [brr_pkg::ACC_W-1:0]     base;
    logic signed [brr_pkg::ACC_W-1:0]     acc;
    logic signed [brr_pkg::SAMPLE_W-1:0]  operand;
    logic signed [brr_pkg::COEF_W-1:0]    weight;
    logic signed [brr_pkg::SAMPLE_W-1:0]  s_sat;
    logic [brr_pkg::CNT_W-1:0]            count_inc;
    logic                                 blk_end;
    brr_pkg::pred_ctl_t                   pred_ctl;

    // Request decode
    assign in_accept   = in_valid && !in_stall;
    assign voice_ok    = int'(voice) < brr_pkg::VOICES;
    assign vidx_in     = voice[brr_pkg::VIDX_W-1:0];
    assign take_header = in_accept && voice_ok && (restart || await_reg[vidx_in]);
    assign start_data  = in_accept && voice_ok && !restart && !await_reg[vidx_in];
    assign vidx        = voice_reg[brr_pkg::VIDX_W-1:0];

    // Header fields of the voice under work
    assign hdr   = header_reg[vidx];
    assign filt  = brr_pkg::filt_t'(hdr[brr_pkg::HDR_FILT_LSB +: 2]);
    assign shift = hdr[brr_pkg::HDR_SHIFT_LSB +: brr_pkg::SHIFT_W];

    // Pick the filter weights
    always_comb
    begin
        w_newer = '0;
        w_older = '0;
        case (filt)
            brr_pkg::FILT_ONE:
            begin
                w_newer = f1_newer_reg;
            end
            brr_pkg::FILT_TWO:
            begin
                w_newer = f2_newer_reg;
                w_older = f2_older_reg;
            end
            brr_pkg::FILT_THREE:
            begin
                w_newer = f3_newer_reg;
                w_older = f3_older_reg;
            end
            default:
            begin
                w_newer = '0;
                w_older = '0;
            end
        endcase
    end

    // Scale the nibble: upper first, sign-extended, shifted by the header
    assign nibble  = nib_sel_reg ? byte_reg[brr_pkg::NIB_W-1:0]
                                 : byte_reg[brr_pkg::BYTE_W-1:brr_pkg::NIB_W];
    assign nib_ext = brr_pkg::ACC_W'($signed(nibble));
    assign base    = nib_ext <<< shift;

    // Saturate and advance the block position
    assign s_sat     = brr_pkg::sat_sample(acc);
    assign count_inc = count_reg[vidx] + brr_pkg::CNT_W'(1);
    assign blk_end   = count_inc >= brr_pkg::CNT_W'(brr_pkg::NIBBLES_PER_BLOCK);
    assign out_free  = !out_valid_reg || !out_stall;

    // Sequencer: next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            brr_pkg::ST_IDLE:
            begin
                if (start_data)
                    state_next = brr_pkg::ST_NEWER;
            end
            brr_pkg::ST_NEWER:
            begin
                state_next = brr_pkg::ST_OLDER;
            end
            brr_pkg::ST_OLDER:
            begin
                state_next = brr_pkg::ST_EMIT;
            end
            brr_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    if (blk_end || nib_sel_reg)
                        state_next = brr_pkg::ST_IDLE;
                    else
                        state_next = brr_pkg::ST_NEWER;
                end
            end
            default:
            begin
                state_next = brr_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer: outputs
    always_comb
    begin
        in_stall       = 1'b1;
        emit_fire      = 1'b0;
        pred_ctl.en    = 1'b0;
        pred_ctl.first = 1'b0;
        operand        = prev_newer_reg[vidx];
        weight         = w_newer;
        case (state_reg)
            brr_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            brr_pkg::ST_NEWER:
            begin
                pred_ctl.en    = 1'b1;
                pred_ctl.first = 1'b1;
            end
            brr_pkg::ST_OLDER:
            begin
                pred_ctl.en = 1'b1;
                operand     = prev_older_reg[vidx];
                weight      = w_older;
            end
            brr_pkg::ST_EMIT:
            begin
                emit_fire = out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= brr_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Shared multiply-accumulate
    brr_pred_unit u_pred (
        .clk     (clk),
        .ctl     (pred_ctl),
        .operand (operand),
        .weight  (weight),
        .base    (base),
        .acc     (acc)
    );

    // Capture the request; step to the lower nibble after the upper one
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            voice_reg <= voice;
            byte_reg  <= data_byte;
        end
        if (start_data)
            nib_sel_reg <= 1'b0;
        else if (emit_fire)
            nib_sel_reg <= 1'b1;
    end

    // Per-voice state: load headers, clear history on restart, advance history on each sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < brr_pkg::VOICES; i++)
            begin
                prev_newer_reg[i] <= '0;
                prev_older_reg[i] <= '0;
                header_reg[i]     <= '0;
                count_reg[i]      <= '0;
                await_reg[i]      <= 1'b1;
            end
        end
        else if (take_header)
        begin
            if (restart)
            begin
                prev_newer_reg[vidx_in] <= '0;
                prev_older_reg[vidx_in] <= '0;
            end
            header_reg[vidx_in] <= data_byte;
            count_reg[vidx_in]  <= '0;
            await_reg[vidx_in]  <= 1'b0;
        end
        else if (emit_fire)
        begin
            prev_older_reg[vidx] <= prev_newer_reg[vidx];
            prev_newer_reg[vidx] <= s_sat;
            count_reg[vidx]      <= blk_end ? '0 : count_inc;
            if (blk_end)
                await_reg[vidx] <= 1'b1;
        end
    end

    // Coefficient writes; drop indices beyond the map
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_newer_reg <= brr_pkg::COEF_F1_NEWER_RST;
            f2_newer_reg <= brr_pkg::COEF_F2_NEWER_RST;
            f2_older_reg <= brr_pkg::COEF_F2_OLDER_RST;
            f3_newer_reg <= brr_pkg::COEF_F3_NEWER_RST;
            f3_older_reg <= brr_pkg::COEF_F3_OLDER_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                brr_pkg::CFG_F1_NEWER: f1_newer_reg <= cfg_data;
                brr_pkg::CFG_F2_NEWER: f2_newer_reg <= cfg_data;
                brr_pkg::CFG_F2_OLDER: f2_older_reg <= cfg_data;
                brr_pkg::CFG_F3_NEWER: f3_newer_reg <= cfg_data;
                brr_pkg::CFG_F3_OLDER: f3_older_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Output register: load when free, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit_fire)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            sample_reg    <= s_sat;
            out_voice_reg <= voice_reg;
            block_end_reg <= blk_end;
            loop_back_reg <= blk_end && hdr[brr_pkg::HDR_END_BIT] && hdr[brr_pkg::HDR_LOOP_BIT];
            stop_play_reg <= blk_end && hdr[brr_pkg::HDR_END_BIT] && !hdr[brr_pkg::HDR_LOOP_BIT];
            last_reg      <= blk_end || nib_sel_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;
    assign out_voice = out_voice_reg;
    assign block_end = block_end_reg;
    assign loop_back = loop_back_reg;
    assign stop_play = stop_play_reg;
    assign last      = last_reg;

    // Checks
    a_load_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == brr_pkg::ST_EMIT))
        else $error("output became valid without a load step");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && block_end) |-> last)
        else $error("block end sample not marked last");

    a_flags_need_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (loop_back || stop_play)) |-> (block_end && !(loop_back && stop_play)))
        else $error("loop or stop flag outside a block end");

    a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && !restart && voice_ok && !await_reg[vidx_in]) |=> in_stall)
        else $error("data request did not stall the input");

endmodule

`default_nettype wire

@@ verif/brr_sample_checker.sv @@
// Result checker for the BRR ADPCM sample decoder: watches the request, result and
// coefficient channels, predicts every sample from its own per-voice history and
// compares field by field. Depends on brr_pkg.

module brr_sample_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 in_valid,
    input  logic                                 in_stall,
    input  logic [brr_pkg::VOICE_W-1:0]          voice,
    input  logic [brr_pkg::BYTE_W-1:0]           data_byte,
    input  logic                                 restart,

    input  logic                                 out_valid,
    input  logic                                 out_stall,
    input  logic signed [brr_pkg::SAMPLE_W-1:0]  sample,
    input  logic [brr_pkg::VOICE_W-1:0]          out_voice,
    input  logic                                 block_end,
    input  logic                                 loop_back,
    input  logic                                 stop_play,
    input  logic                                 last,

    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  logic [brr_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [brr_pkg::COEF_W-1:0]           cfg_data,

    output int                                   fails,
    output int                                   pending
);
    import brr_pkg::*;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic [VOICE_W-1:0]         voice;
        logic                       block_end;
        logic                       loop_back;
        logic                       stop_play;
        logic                       last;
    } pcm_result_t;

    // Filter weights, in 64ths
    logic signed [COEF_W-1:0]   w_f1_newer;
    logic signed [COEF_W-1:0]   w_f2_newer;
    logic signed [COEF_W-1:0]   w_f2_older;
    logic signed [COEF_W-1:0]   w_f3_newer;
    logic signed [COEF_W-1:0]   w_f3_older;

    // Per-voice decoder state
    logic signed [SAMPLE_W-1:0] hist_newer [VOICES];
    logic signed [SAMPLE_W-1:0] hist_older [VOICES];
    logic [BYTE_W-1:0]          hdr_byte   [VOICES];
    logic [CNT_W-1:0]           nib_pos    [VOICES];
    logic                       want_header[VOICES];

    pcm_result_t                due_samples[$];
    int                         fail_count;

    // Decode one nibble against the voice's header and history, then advance history
    function automatic logic signed [SAMPLE_W-1:0] predict_nibble(
        input int               v,
        input logic [NIB_W-1:0] nib
    );
        logic [SHIFT_W-1:0]      shift;
        filt_t                   filt;
        logic signed [NIB_W-1:0] nib_s;
        int                      acc;
        int                      wn;
        int                      wo;
        shift = hdr_byte[v][HDR_SHIFT_LSB +: SHIFT_W];
        filt  = filt_t'(hdr_byte[v][HDR_FILT_LSB +: 2]);
        nib_s = nib;
        wn    = 0;
        wo    = 0;
        case (filt)
            FILT_ONE:
            begin
                wn = int'(w_f1_newer);
            end
            FILT_TWO:
            begin
                wn = int'(w_f2_newer);
                wo = int'(w_f2_older);
            end
            FILT_THREE:
            begin
                wn = int'(w_f3_newer);
                wo = int'(w_f3_older);
            end
            default:
            begin
                wn = 0;
            end
        endcase
        acc = int'(nib_s) <<< shift;
        acc = acc + ((int'(hist_newer[v]) * wn) >>> FRAC_BITS);
        acc = acc + ((int'(hist_older[v]) * wo) >>> FRAC_BITS);
        if (acc > SAMPLE_MAX)
            acc = SAMPLE_MAX;
        if (acc < SAMPLE_MIN)
            acc = SAMPLE_MIN;
        hist_older[v] = hist_newer[v];
        hist_newer[v] = SAMPLE_W'(acc);
        return SAMPLE_W'(acc);
    endfunction

    // Take one accepted request and queue the samples it must produce
    task automatic decode_byte(input int v, input logic [BYTE_W-1:0] b, input logic rs);
        pcm_result_t      r;
        logic [NIB_W-1:0] nib;
        if (v >= VOICES)
            return;
        if (rs)
        begin
            hist_newer[v]  = '0;
            hist_older[v]  = '0;
            nib_pos[v]     = '0;
            want_header[v] = 1'b1;
        end
        if (want_header[v])
        begin
            hdr_byte[v]    = b;
            nib_pos[v]     = '0;
            want_header[v] = 1'b0;
            return;
        end
        for (int k = 0; k < 2; k++)
        begin
            nib         = (k == 0) ? b[BYTE_W-1 -: NIB_W] : b[NIB_W-1:0];
            r.sample    = predict_nibble(v, nib);
            r.voice     = VOICE_W'(v);
            nib_pos[v]  = nib_pos[v] + CNT_W'(1);
            r.block_end = (int'(nib_pos[v]) >= NIBBLES_PER_BLOCK);
            r.loop_back = r.block_end && hdr_byte[v][HDR_END_BIT] && hdr_byte[v][HDR_LOOP_BIT];
            r.stop_play = r.block_end && hdr_byte[v][HDR_END_BIT] && !hdr_byte[v][HDR_LOOP_BIT];
            r.last      = r.block_end || (k == 1);
            if (r.block_end)
            begin
                nib_pos[v]     = '0;
                want_header[v] = 1'b1;
            end
            due_samples.push_back(r);
            if (r.block_end)
                break;
        end
    endtask

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Track coefficient writes, compare results, then predict new requests
    always @(posedge clk or negedge rst_n)
    begin
        pcm_result_t want;
        if (!rst_n)
        begin
            w_f1_newer = COEF_F1_NEWER_RST;
            w_f2_newer = COEF_F2_NEWER_RST;
            w_f2_older = COEF_F2_OLDER_RST;
            w_f3_newer = COEF_F3_NEWER_RST;
            w_f3_older = COEF_F3_OLDER_RST;
            for (int i = 0; i < VOICES; i++)
            begin
                hist_newer[i]  = '0;
                hist_older[i]  = '0;
                hdr_byte[i]    = '0;
                nib_pos[i]     = '0;
                want_header[i] = 1'b1;
            end
            due_samples.delete();
            fail_count = 0;
            fails   <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_reg_t'(cfg_index))
                    CFG_F1_NEWER: w_f1_newer = cfg_data;
                    CFG_F2_NEWER: w_f2_newer = cfg_data;
                    CFG_F2_OLDER: w_f2_older = cfg_data;
                    CFG_F3_NEWER: w_f3_newer = cfg_data;
                    CFG_F3_OLDER: w_f3_older = cfg_data;
                    default:      ;
                endcase
            end

            if (out_valid && !out_stall)
            begin
                if (due_samples.size() == 0)
                begin
                    $error("unexpected sample %0d on voice %0d", sample, out_voice);
                    fail_count++;
                end
                else
                begin
                    want = due_samples.pop_front();
                    check_field("sample", int'(want.sample), int'(sample));
                    check_field("out_voice", int'(want.voice), int'(out_voice));
                    check_field("block_end", int'(want.block_end), int'(block_end));
                    check_field("loop_back", int'(want.loop_back), int'(loop_back));
                    check_field("stop_play", int'(want.stop_play), int'(stop_play));
                    check_field("last", int'(want.last), int'(last));
                end
            end

            if (in_valid && !in_stall)
                decode_byte(int'(voice), data_byte, restart);

            fails   <= fail_count;
            pending <= due_samples.size();
        end
    end

endmodule

@@ verif/tb.sv @@
// Testbench top for the BRR ADPCM sample decoder: clock, reset, request stimulus,
// coefficient phases, output back-pressure and the verdict.
// Depends on brr_pkg, brr_adpcm_sample_decoder_top and brr_sample_checker.

module tb;
    import brr_pkg::*;

    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASE_BYTES   = 365;
    localparam int BLOCK_BYTES   = NIBBLES_PER_BLOCK / 2;

    typedef enum {COEF_LOW, COEF_HIGH, COEF_RANDOM} coef_set_t;

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_stall;
    logic [VOICE_W-1:0]          voice;
    logic [BYTE_W-1:0]           data_byte;
    logic                        restart;
    logic                        out_valid;
    logic                        out_stall;
    logic signed [SAMPLE_W-1:0]  sample;
    logic [VOICE_W-1:0]          out_voice;
    logic                        block_end;
    logic                        loop_back;
    logic                        stop_play;
    logic                        last;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [CFG_IDX_W-1:0]        cfg_index;
    logic [COEF_W-1:0]           cfg_data;

    int                          fails;
    int                          pending;
    int                          idle_odds;
    int                          quiet_cycles;
    int                          blk_left[VOICES];

    brr_adpcm_sample_decoder_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .voice     (voice),
        .data_byte (data_byte),
        .restart   (restart),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sample    (sample),
        .out_voice (out_voice),
        .block_end (block_end),
        .loop_back (loop_back),
        .stop_play (stop_play),
        .last      (last),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    brr_sample_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .voice     (voice),
        .data_byte (data_byte),
        .restart   (restart),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sample    (sample),
        .out_voice (out_voice),
        .block_end (block_end),
        .loop_back (loop_back),
        .stop_play (stop_play),
        .last      (last),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fails     (fails),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Stall the result channel in random bursts while idling is enabled
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (idle_odds != 0 && $urandom_range(1, 2 * idle_odds) == 1)
            begin
                out_stall = 1'b1;
                repeat ($urandom_range(0, 13)) @(negedge clk);
            end
            else
            begin
                out_stall = 1'b0;
            end
        end
    end

    // Abort when no channel has moved for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Present one request, optionally after a gap, and hold it until accepted
    task automatic send_byte(input int v, input logic [BYTE_W-1:0] b, input logic rs);
        int gap;
        gap = 0;
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
            gap = $urandom_range(1, 14);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        voice     = VOICE_W'(v);
        data_byte = b;
        restart   = rs;
        in_valid  = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        if (rs || blk_left[v] == 0)
            blk_left[v] = BLOCK_BYTES;
        else
            blk_left[v] = blk_left[v] - 1;
    endtask

    // Mostly sensible shifts, now and then one that overflows
    function automatic logic [BYTE_W-1:0] make_header();
        logic [SHIFT_W-1:0] shift;
        logic [1:0]         filt;
        logic               loop_flag;
        logic               end_flag;
        if ($urandom_range(0, 9) == 0)
            shift = SHIFT_W'($urandom_range(13, 15));
        else
            shift = SHIFT_W'($urandom_range(0, 12));
        filt      = 2'($urandom_range(0, 3));
        loop_flag = 1'($urandom_range(0, 1));
        end_flag  = 1'($urandom_range(0, 1));
        return {shift, filt, loop_flag, end_flag};
    endfunction

    // Well-formed blocks per voice with random content, plus restarts and junk headers
    task automatic stream_bytes(input int count, input int odds);
        int               v;
        logic [BYTE_W-1:0] b;
        logic             rs;
        for (int k = 0; k < count; k++)
        begin
            idle_odds = ((k / 60) % 2 == 1) ? 0 : odds;
            v  = $urandom_range(0, VOICES - 1);
            rs = 1'b0;
            if ($urandom_range(0, 39) == 0)
            begin
                rs = 1'b1;
                b  = make_header();
            end
            else if (blk_left[v] == 0)
            begin
                if ($urandom_range(0, 19) == 0)
                    b = BYTE_W'($urandom_range(0, 255));
                else
                    b = make_header();
            end
            else
            begin
                b = BYTE_W'($urandom_range(0, 255));
            end
            send_byte(v, b, rs);
        end
    endtask

    task automatic write_coef(input int idx, input logic [COEF_W-1:0] val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = CFG_IDX_W'(idx);
        cfg_data  = val;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // Write every weight, then the unused indexes, which must be dropped
    task automatic load_coefs(input coef_set_t set);
        logic [COEF_W-1:0] val;
        for (int i = CFG_F1_NEWER; i <= CFG_F3_OLDER; i++)
        begin
            case (set)
                COEF_LOW:  val = 8'h80;
                COEF_HIGH: val = 8'h7F;
                default:   val = COEF_W'($urandom_range(0, 255));
            endcase
            write_coef(i, val);
        end
        for (int i = CFG_F3_OLDER + 1; i < (1 << CFG_IDX_W); i++)
            write_coef(i, COEF_W'($urandom_range(0, 255)));
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Hold off requests until every sample is out and the sequencer is quiet
    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        voice     = '0;
        data_byte = '0;
        restart   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        idle_odds = 0;
        for (int i = 0; i < VOICES; i++)
            blk_left[i] = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: field extremes, every filter, both saturations, flags, restart
        idle_odds = 4;
        send_byte(0, 8'hC0, 1'b1);
        send_byte(0, 8'h7F, 1'b0);
        send_byte(0, 8'h80, 1'b0);
        send_byte(0, 8'h08, 1'b0);
        send_byte(0, 8'hF0, 1'b0);
        send_byte(0, 8'h00, 1'b0);
        send_byte(0, 8'hFF, 1'b0);
        send_byte(0, 8'h77, 1'b0);
        send_byte(0, 8'h88, 1'b0);
        send_byte(7, 8'hFF, 1'b1);
        send_byte(7, 8'h77, 1'b0);
        send_byte(7, 8'h88, 1'b0);
        send_byte(3, 8'h26, 1'b0);
        send_byte(3, 8'h9A, 1'b0);
        // restart in the middle of a block, then a full block ending with loop
        send_byte(7, 8'h5B, 1'b1);
        for (int i = 0; i < BLOCK_BYTES; i++)
            send_byte(7, BYTE_W'($urandom_range(0, 255)), 1'b0);

        stream_bytes(PHASE_BYTES, 3);

        settle();
        load_coefs(COEF_LOW);
        stream_bytes(PHASE_BYTES, 6);

        settle();
        load_coefs(COEF_HIGH);
        stream_bytes(PHASE_BYTES, 2);

        settle();
        load_coefs(COEF_RANDOM);
        stream_bytes(PHASE_BYTES, 5);

        // Closing stretch at full rate on both sides
        settle();
        load_coefs(COEF_RANDOM);
        stream_bytes(PHASE_BYTES, 0);

        settle();
        if (fails == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
